// File: sv/tkh_pkg.sv
// Shared types, constants and codes for the top-k min-heap selector.
// No dependencies; every other file of the block imports this package.
package tkh_pkg;

   localparam int SCORE_W = 32;
   localparam int ID_W    = 14;
   localparam int KEEP_W  = 10;

   localparam logic [KEEP_W-1:0] KEEP_RESET = 10'd10;

   // request codes carried in req_type
   localparam logic REQ_OFFER = 1'b0;
   localparam logic REQ_POP   = 1'b1;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [ID_W-1:0]    id;
   } item_type;

   // what the sequencer hands to the output register
   typedef struct packed {
      logic     found;
      item_type item;
   } result_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_FULL_RD,
      ST_FULL_CMP,
      ST_RM_RD0,
      ST_RM_RD1,
      ST_RM_RD2,
      ST_DN_RD_L,
      ST_DN_RD_R,
      ST_DN_PICK,
      ST_DN_CMP,
      ST_FIN
   } seq_state_type;

endpackage

// File: sv/tkh_req_if.sv
// Request channel of the top-k min-heap selector: valid/ready plus payload.
// Depends on tkh_pkg for field widths.
interface tkh_req_if import tkh_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               req_type;
   logic [SCORE_W-1:0] in_score;
   logic [ID_W-1:0]    in_id;

   modport source (output valid, req_type, in_score, in_id, input ready);
   modport sink   (input valid, req_type, in_score, in_id, output ready);
endinterface

// File: sv/tkh_rsp_if.sv
// Response channel of the top-k min-heap selector: valid/ready plus payload.
// Depends on tkh_pkg for field widths; CNT_W sizes kept_count.
interface tkh_rsp_if import tkh_pkg::*; #(parameter int CNT_W = 11) ();
   logic               valid;
   logic               ready;
   logic               out_valid;
   logic [SCORE_W-1:0] out_score;
   logic [ID_W-1:0]    out_id;
   logic [CNT_W-1:0]   kept_count;

   modport source (output valid, out_valid, out_score, out_id, kept_count, input ready);
   modport sink   (input valid, out_valid, out_score, out_id, kept_count, output ready);
endinterface

// File: sv/tkh_rank.sv
// Shared rank comparator: true when lhs ranks strictly below rhs.
// Depends on tkh_pkg (item_type).
module tkh_rank import tkh_pkg::*; (
   input  item_type lhs,
   input  item_type rhs,
   output logic     below
);

   always_comb begin
      if (lhs.score == rhs.score) begin
         below = lhs.id > rhs.id;
      end else begin
         below = lhs.score < rhs.score;
      end
   end

endmodule

// File: sv/tkh_seq.sv
// Heap sequencer: heap memory, item count and the sift-up / sift-down walk.
// Depends on tkh_pkg and instantiates the shared comparator tkh_rank.
module tkh_seq import tkh_pkg::*; #(
   parameter int CAPACITY = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         start_op,
   input  item_type                     start_item,
   input  logic [KEEP_W-1:0]            k_keep,
   input  logic                         ack,
   output logic                         idle,
   output logic                         fin,
   output result_type                   result,
   output logic [$clog2(CAPACITY+1)-1:0] count
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CH_W  = IDX_W + 1;
   localparam int CMP_W = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;

   seq_state_type state_ff, state_in;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [CH_W-1:0]  child_ff, child_in;
   item_type         key_ff, key_in;
   item_type         pick_ff, pick_in;
   item_type         ev_ff, ev_in;
   logic             found_ff, found_in;
   item_type         rdata_ff;

   item_type heap_mem [CAPACITY];

   logic             rd_en, wr_en;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   item_type         wr_data;
   item_type         cmp_lhs, cmp_rhs;
   logic             below;

   logic [IDX_W-1:0] parent;
   logic [IDX_W-1:0] child_lo;
   logic [CNT_W-1:0] inc_count, count_m1;
   logic             child_in_range, right_in_range, evict_due;

   tkh_rank u_rank (
      .lhs   (cmp_lhs),
      .rhs   (cmp_rhs),
      .below (below)
   );

   assign parent         = (pos_ff - IDX_W'(1)) >> 1;
   assign child_lo       = child_ff[IDX_W-1:0];
   assign inc_count      = count_ff + CNT_W'(1);
   assign count_m1       = count_ff - CNT_W'(1);
   assign child_in_range = child_ff < CH_W'(n_ff);
   assign right_in_range = (child_ff + CH_W'(1)) < CH_W'(n_ff);
   assign evict_due      = CMP_W'(inc_count) > CMP_W'(k_keep);

   // heap storage: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= heap_mem[rd_addr];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (start_op == REQ_POP) begin
                  state_in = (count_ff == '0) ? ST_FIN : ST_RM_RD0;
               end else begin
                  state_in = (count_ff == CNT_W'(CAPACITY)) ? ST_FULL_RD : ST_UP_RD;
               end
            end
         end
         ST_UP_RD: begin
            if (pos_ff == '0) begin
               state_in = evict_due ? ST_RM_RD0 : ST_FIN;
            end else begin
               state_in = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            if (!below) begin
               state_in = ST_UP_RD;
            end else begin
               state_in = evict_due ? ST_RM_RD0 : ST_FIN;
            end
         end
         ST_FULL_RD:  state_in = ST_FULL_CMP;
         ST_FULL_CMP: state_in = below ? ST_DN_RD_L : ST_FIN;
         ST_RM_RD0:   state_in = ST_RM_RD1;
         ST_RM_RD1:   state_in = ST_RM_RD2;
         ST_RM_RD2:   state_in = ST_DN_RD_L;
         ST_DN_RD_L:  state_in = child_in_range ? ST_DN_RD_R : ST_FIN;
         ST_DN_RD_R:  state_in = right_in_range ? ST_DN_PICK : ST_DN_CMP;
         ST_DN_PICK:  state_in = ST_DN_CMP;
         ST_DN_CMP:   state_in = below ? ST_FIN : ST_DN_RD_L;
         ST_FIN:      state_in = ack ? ST_IDLE : ST_FIN;
         default:     state_in = ST_IDLE;
      endcase
   end

   // memory port and comparator operand selection
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = pos_ff;
      wr_data = key_ff;
      cmp_lhs = rdata_ff;
      cmp_rhs = key_ff;
      case (state_ff)
         ST_UP_RD: begin
            if (pos_ff == '0) begin
               wr_en = 1'b1;
            end else begin
               rd_en   = 1'b1;
               rd_addr = parent;
            end
         end
         ST_UP_CMP: begin
            wr_en   = 1'b1;
            wr_data = below ? key_ff : rdata_ff;
         end
         ST_FULL_RD, ST_RM_RD0: begin
            rd_en = 1'b1;
         end
         ST_RM_RD1: begin
            rd_en   = 1'b1;
            rd_addr = count_m1[IDX_W-1:0];
         end
         ST_DN_RD_L: begin
            if (child_in_range) begin
               rd_en   = 1'b1;
               rd_addr = child_lo;
            end else begin
               wr_en = 1'b1;
            end
         end
         ST_DN_RD_R: begin
            if (right_in_range) begin
               rd_en   = 1'b1;
               rd_addr = child_lo + IDX_W'(1);
            end
         end
         ST_DN_PICK: begin
            cmp_lhs = pick_ff;
            cmp_rhs = rdata_ff;
         end
         ST_DN_CMP: begin
            cmp_lhs = key_ff;
            cmp_rhs = pick_ff;
            wr_en   = 1'b1;
            wr_data = below ? key_ff : pick_ff;
         end
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      count_in = count_ff;
      n_in     = n_ff;
      pos_in   = pos_ff;
      child_in = child_ff;
      key_in   = key_ff;
      pick_in  = pick_ff;
      ev_in    = ev_ff;
      found_in = found_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in   = start_item;
               ev_in    = '0;
               found_in = 1'b0;
               pos_in   = count_ff[IDX_W-1:0];
            end
         end
         ST_UP_RD: begin
            if (pos_ff == '0) begin
               count_in = inc_count;
            end
         end
         ST_UP_CMP: begin
            if (!below) begin
               pos_in = parent;
            end else begin
               count_in = inc_count;
            end
         end
         ST_FULL_CMP: begin
            found_in = 1'b1;
            ev_in    = below ? rdata_ff : key_ff;
            n_in     = CNT_W'(CAPACITY);
            pos_in   = '0;
            child_in = CH_W'(1);
         end
         ST_RM_RD1: begin
            ev_in    = rdata_ff;
            found_in = 1'b1;
         end
         ST_RM_RD2: begin
            key_in   = rdata_ff;
            count_in = count_m1;
            n_in     = count_m1;
            pos_in   = '0;
            child_in = CH_W'(1);
         end
         ST_DN_RD_R: begin
            pick_in = rdata_ff;
         end
         ST_DN_PICK: begin
            if (!below) begin
               pick_in  = rdata_ff;
               child_in = child_ff + CH_W'(1);
            end
         end
         ST_DN_CMP: begin
            if (!below) begin
               pos_in   = child_lo;
               child_in = {child_lo, 1'b1};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      n_ff     <= n_in;
      pos_ff   <= pos_in;
      child_ff <= child_in;
      key_ff   <= key_in;
      pick_ff  <= pick_in;
      ev_ff    <= ev_in;
      found_ff <= found_in;
   end

   assign idle         = state_ff == ST_IDLE;
   assign fin          = state_ff == ST_FIN;
   assign result.found = found_ff;
   assign result.item  = ev_ff;
   assign count        = count_ff;

endmodule

// File: sv/top_k_min_heap_selector.sv
// Walk: an offer climbs from the new end slot toward the root; an eviction or pop reads the
//   root and the last entry, then walks the last entry down from the root. A full-heap offer
//   compares the newcomer with the root and walks it down from the root if the root leaves.
// Throughput: one item at a time, paced by the one heap read port and the shared comparator.
// Reset (synchronous, active high): empties the heap and sets k_keep to 10; heap memory
//   contents are not cleared, and only entries below the count are ever read.
module top_k_min_heap_selector import tkh_pkg::*; #(
   parameter int CAPACITY = 1024
) (
   input  logic              clock,
   input  logic              reset,
   tkh_req_if.sink           req_bus,
   tkh_rsp_if.source         rsp_bus,
   input  logic              csr_wr_en,
   input  logic [KEEP_W-1:0] csr_wr_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [KEEP_W-1:0] k_keep_ff;

   logic              seq_idle;
   logic              seq_fin;
   logic              seq_start;
   logic              seq_ack;
   result_type        seq_result;
   logic [CNT_W-1:0]  seq_count;

   logic              rsp_vld_ff;
   result_type        rsp_res_ff;
   logic [CNT_W-1:0]  rsp_cnt_ff;

   // Configuration: the user must write k_keep only while the block is idle (not enforced).
   always_ff @(posedge clock) begin
      if (reset) begin
         k_keep_ff <= KEEP_RESET;
      end else if (csr_wr_en) begin
         k_keep_ff <= csr_wr_data;
      end
   end

   // Take a request beat only while the sequencer sits idle; a result waiting in the output
   // register lets one more request run, whose result then waits in ST_FIN until it frees.
   assign req_bus.ready = seq_idle;
   assign seq_start     = req_bus.valid && seq_idle;

   tkh_seq #(
      .CAPACITY (CAPACITY)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (seq_start),
      .start_op   (req_bus.req_type),
      .start_item ({req_bus.in_score, req_bus.in_id}),
      .k_keep     (k_keep_ff),
      .ack        (seq_ack),
      .idle       (seq_idle),
      .fin        (seq_fin),
      .result     (seq_result),
      .count      (seq_count)
   );

   // Hand the finished result over once the output register is free or draining.
   assign seq_ack = seq_fin && (!rsp_vld_ff || rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (seq_ack) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_vld_ff <= 1'b0;
      end
      // hold the payload until the next result is handed over
      if (seq_ack) begin
         rsp_res_ff <= seq_result;
         rsp_cnt_ff <= seq_count;
      end
   end

   assign rsp_bus.valid      = rsp_vld_ff;
   assign rsp_bus.out_valid  = rsp_res_ff.found;
   assign rsp_bus.out_score  = rsp_res_ff.item.score;
   assign rsp_bus.out_id     = rsp_res_ff.item.id;
   assign rsp_bus.kept_count = rsp_cnt_ff;

endmodule

// File: sv/tkh_chk.sv
// Port-level checker for the top-k min-heap selector, bound to the top level.
// Depends on tkh_pkg for field widths.
module tkh_chk import tkh_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_found,
   input logic [SCORE_W-1:0] rsp_score,
   input logic [ID_W-1:0]    rsp_id
);

   // a stalled response beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) && $stable(rsp_score)
         && $stable(rsp_id))
      else $error("response beat changed while stalled");

   // reset leaves no response pending
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a request beat starts a multi-cycle walk; ready drops behind it
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while sequencer busy");

   // a response with no item reported carries zero fields
   a_no_item_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_score == '0 && rsp_id == '0)
      else $error("empty response carries item fields");

endmodule

bind top_k_min_heap_selector tkh_chk u_tkh_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_found (rsp_bus.out_valid),
   .rsp_score (rsp_bus.out_score),
   .rsp_id    (rsp_bus.out_id)
);

// File: tb/sv/tb_top_k_min_heap_selector.sv
// Self-checking bench for top_k_min_heap_selector: directed rows, then random phases.
// Uses tkh_pkg and the tkh_req_if / tkh_rsp_if channels; a local heap predicts untyped results.
module tb_top_k_min_heap_selector;
   import tkh_pkg::*;

   localparam int CAPACITY  = 1024;
   localparam int COUNT_W   = 11;
   localparam int RUN_LIMIT = 12_000_000;   // time units, several times the slowest good run
   localparam int LONG_HOLD = 600;          // cycles the receiver stays off once
   localparam int HOLD_AT   = 700;          // result beats seen before that hold-off

   typedef struct packed {
      logic               found;
      item_type           item;
      logic [COUNT_W-1:0] count;
   } outcome_t;

   typedef enum logic {ROW_BEAT, ROW_KEEP} row_kind_t;

   typedef struct {
      row_kind_t         kind;
      logic              req;
      item_type          item;
      logic [KEEP_W-1:0] keep;
      bit                typed;     // want holds a hand-written outcome
      outcome_t          want;
   } plan_row_t;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [KEEP_W-1:0] csr_wr_data;

   tkh_req_if                        req_bus ();
   tkh_rsp_if #(.CNT_W(COUNT_W))     rsp_bus ();

   top_k_min_heap_selector #(.CAPACITY(CAPACITY)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Predicted heap, kept apart from the block: its own array, fill and keep limit.
   item_type          heap_copy [CAPACITY];
   int unsigned       heap_fill;
   logic [KEEP_W-1:0] keep_limit;

   outcome_t  pending_outcomes [$];   // one entry per accepted request beat, oldest first
   plan_row_t plan [$];
   int        fail_count = 0;
   int        beats_seen = 0;

   // Random phases: keep setting, request count, share of pops in percent.
   int phase_keep [5] = '{1, 0, 1023, 6, 37};
   int phase_len  [5] = '{150, 100, 1060, 200, 215};
   int phase_pops [5] = '{30, 20, 0, 50, 25};

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   // a ranks strictly below b: lower score, or equal score and larger id
   function automatic bit ranks_lower(item_type a, item_type b);
      if (a.score == b.score) return a.id > b.id;
      return a.score < b.score;
   endfunction

   // Drop it into slot and push it down while a child ranks no higher.
   function automatic void settle_down(int unsigned slot, item_type it, int unsigned n);
      int unsigned child = 2 * slot + 1;
      while (child < n) begin
         if (child + 1 < n && !ranks_lower(heap_copy[child], heap_copy[child + 1]))
            child++;
         if (ranks_lower(it, heap_copy[child])) break;
         heap_copy[slot] = heap_copy[child];
         slot  = child;
         child = 2 * slot + 1;
      end
      heap_copy[slot] = it;
   endfunction

   // Append it at the end and climb while the parent ranks no lower than it.
   function automatic void climb_in(item_type it);
      int unsigned i = heap_fill;
      int unsigned p;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (ranks_lower(heap_copy[p], it)) break;
         heap_copy[i] = heap_copy[p];
         i = p;
      end
      heap_copy[i] = it;
      heap_fill++;
   endfunction

   function automatic item_type take_root();
      item_type top  = heap_copy[0];
      item_type last = heap_copy[heap_fill - 1];
      heap_fill--;
      settle_down(0, last, heap_fill);
      return top;
   endfunction

   // Advance the predicted heap by one request and return the result it must produce.
   function automatic outcome_t heap_step(logic req, item_type it);
      outcome_t res = '0;
      if (req == REQ_OFFER) begin
         if (heap_fill >= CAPACITY) begin
            // full heap: the worse of the newcomer and the root leaves
            res.found = 1'b1;
            if (!ranks_lower(heap_copy[0], it)) begin
               res.item = it;
            end else begin
               res.item = heap_copy[0];
               settle_down(0, it, CAPACITY);
            end
         end else begin
            climb_in(it);
            if (heap_fill > keep_limit) begin
               res.found = 1'b1;
               res.item  = take_root();
            end
         end
      end else if (heap_fill > 0) begin
         res.found = 1'b1;
         res.item  = take_root();
      end
      res.count = COUNT_W'(heap_fill);
      return res;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic plan_row_t beat_row(logic req, logic [SCORE_W-1:0] sc,
                                          logic [ID_W-1:0] id);
      plan_row_t r;
      r.kind       = ROW_BEAT;
      r.req        = req;
      r.item.score = sc;
      r.item.id    = id;
      r.keep       = '0;
      r.typed      = 1'b0;
      r.want       = '0;
      return r;
   endfunction

   function automatic plan_row_t typed_row(logic req, logic [SCORE_W-1:0] sc,
                                           logic [ID_W-1:0] id, logic found,
                                           logic [SCORE_W-1:0] out_sc, logic [ID_W-1:0] out_id,
                                           logic [COUNT_W-1:0] cnt);
      plan_row_t r = beat_row(req, sc, id);
      r.typed            = 1'b1;
      r.want.found       = found;
      r.want.item.score  = out_sc;
      r.want.item.id     = out_id;
      r.want.count       = cnt;
      return r;
   endfunction

   function automatic plan_row_t keep_row(logic [KEEP_W-1:0] k);
      plan_row_t r = beat_row(REQ_OFFER, '0, '0);
      r.kind = ROW_KEEP;
      r.keep = k;
      return r;
   endfunction

   // Scores cluster on a few values three times in four so that ties and equal items recur.
   function automatic item_type random_item();
      item_type it;
      case ($urandom_range(3))
         0: it.score = $urandom();
         1: it.score = $urandom_range(7);
         2: it.score = {14'd0, 2'($urandom_range(3)), $urandom_range(1) ? 16'h8000 : 16'h0000};
         default: it.score = 32'hFFFF_FFFF - $urandom_range(3);
      endcase
      if ($urandom_range(1))
         it.id = ID_W'($urandom_range(16383));
      else
         it.id = ID_W'($urandom_range(3));
      return it;
   endfunction

   // Sender gap after a beat: mostly none or short, a few long, and hot runs with none at all.
   int hot_run = 0;
   function automatic int sender_gap();
      int r;
      if (hot_run > 0) begin
         hot_run--;
         return 0;
      end
      r = $urandom_range(99);
      if (r < 4) begin
         hot_run = $urandom_range(60, 20);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // Entered right after a rising edge; returns at the edge where the beat was taken,
   // with valid still high so that a follow-on beat needs no extra edge.
   task automatic send_beat(logic req, item_type it, bit typed, outcome_t want);
      outcome_t predicted;
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= req;
      req_bus.in_score <= it.score;
      req_bus.in_id    <= it.id;
      do @(posedge clock); while (!req_bus.ready);
      predicted = heap_step(req, it);
      pending_outcomes.push_back(typed ? want : predicted);
   endtask

   task automatic idle_after_beat();
      int gap = sender_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold the request side until every result is back.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   // Write k_keep only with the block idle: every result home, plus a short settle.
   task automatic set_keep(logic [KEEP_W-1:0] k);
      drain_results();
      repeat (6) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= k;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      keep_limit   = k;
   endtask

   // ---------------------------------------------------------------- request side

   initial begin : stimulus
      item_type it;
      logic     req;
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.req_type <= REQ_OFFER;
      req_bus.in_score <= '0;
      req_bus.in_id    <= '0;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= '0;
      heap_fill         = 0;
      keep_limit        = KEEP_RESET;

      // Directed rows. Typed outcomes are the ones obvious by hand; the rest use the predictor.
      // Pops carry junk in the item fields, which the block must ignore.
      plan.push_back(typed_row(REQ_POP,   32'hFFFF_FFFF, 14'h3FFF, 0, 0, 0, 0)); // empty pop
      plan.push_back(typed_row(REQ_OFFER, 32'h0000_0000, 14'h0000, 0, 0, 0, 1));
      plan.push_back(typed_row(REQ_POP,   32'h0000_0000, 14'h0000, 1, 0, 0, 0));
      plan.push_back(typed_row(REQ_OFFER, 32'hFFFF_FFFF, 14'h3FFF, 0, 0, 0, 1));
      plan.push_back(beat_row (REQ_OFFER, 32'hFFFF_FFFF, 14'h0000));
      plan.push_back(beat_row (REQ_OFFER, 32'h0001_8000, 14'h0005));
      plan.push_back(beat_row (REQ_OFFER, 32'h0001_8000, 14'h0005));          // identical item
      plan.push_back(beat_row (REQ_OFFER, 32'h0001_8000, 14'h0004));          // tie, smaller id
      repeat (5) plan.push_back(beat_row(REQ_POP, 32'h5A5A_A5A5, 14'h2AAA));
      plan.push_back(typed_row(REQ_POP,   32'h0000_0000, 14'h0000, 0, 0, 0, 0)); // empty again
      plan.push_back(keep_row(10'd0));
      // keep of zero: every offer bounces straight back out
      plan.push_back(typed_row(REQ_OFFER, 32'h1234_5678, 14'h0064, 1, 32'h1234_5678, 14'h0064, 0));
      plan.push_back(typed_row(REQ_OFFER, 32'h0000_0000, 14'h3FFF, 1, 32'h0000_0000, 14'h3FFF, 0));
      plan.push_back(keep_row(10'd1));
      plan.push_back(typed_row(REQ_OFFER, 32'h0000_0005, 14'h0007, 0, 0, 0, 1));
      plan.push_back(typed_row(REQ_OFFER, 32'h0000_0009, 14'h0001, 1, 32'h0000_0005, 14'h0007, 1));
      plan.push_back(beat_row (REQ_OFFER, 32'h0000_0009, 14'h0002));
      plan.push_back(keep_row(10'd4));
      plan.push_back(beat_row (REQ_OFFER, 32'h0000_0007, 14'h0001));
      plan.push_back(beat_row (REQ_OFFER, 32'h0000_0003, 14'h0002));
      plan.push_back(beat_row (REQ_OFFER, 32'h8000_0000, 14'h0009));
      plan.push_back(beat_row (REQ_OFFER, 32'h0000_0003, 14'h0001));
      // lower the keep limit under the count: offers still evict only one each
      plan.push_back(keep_row(10'd2));
      plan.push_back(beat_row (REQ_OFFER, 32'h0000_0001, 14'h0001));
      plan.push_back(beat_row (REQ_POP,   32'h0000_0000, 14'h0000));

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_KEEP) begin
            set_keep(plan[i].keep);
         end else begin
            send_beat(plan[i].req, plan[i].item, plan[i].typed, plan[i].want);
            idle_after_beat();
         end
      end

      // Random phases. The keep=1023 phase is offer-only so the heap fills to the keep limit;
      // the phases after it lower the limit far under the count and shrink it only through pops.
      for (int p = 0; p < 5; p++) begin
         set_keep(KEEP_W'(phase_keep[p]));
         for (int n = 0; n < phase_len[p]; n++) begin
            if (p == 1 && n == phase_len[p] / 2) drain_results();
            req = ($urandom_range(99) < phase_pops[p]) ? REQ_POP : REQ_OFFER;
            it  = random_item();
            send_beat(req, it, 1'b0, '0);
            idle_after_beat();
         end
      end

      drain_results();
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // ---------------------------------------------------------------- result side

   // Ready with random stalls, mostly short, a few long, and calm stretches with none.
   // Once, hold ready low for a long stretch so the request side backs up and stalls.
   initial begin : receiver
      int stall     = 0;
      int calm      = 0;
      int r;
      bit held_once = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!held_once && beats_seen >= HOLD_AT) begin
            held_once = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            stall--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (calm > 0) begin
               calm--;
            end else begin
               r = $urandom_range(99);
               if (r < 15)
                  stall = $urandom_range(3, 1);
               else if (r < 17)
                  stall = $urandom_range(60, 15);
               else if (r < 20)
                  calm = $urandom_range(200, 40);
            end
         end
      end
   end

   task automatic note_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endtask

   // Check each result beat against the oldest pending outcome.
   always @(posedge clock) begin : result_check
      outcome_t want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         beats_seen++;
         if (pending_outcomes.size() == 0) begin
            fail_count++;
            $display("%0t: result beat with nothing expected, got valid %b score %h id %h count %0d",
                     $time, rsp_bus.out_valid, rsp_bus.out_score, rsp_bus.out_id,
                     rsp_bus.kept_count);
         end else begin
            want = pending_outcomes.pop_front();
            note_field("out_valid",  32'(want.found),      32'(rsp_bus.out_valid));
            note_field("out_score",  want.item.score,      rsp_bus.out_score);
            note_field("out_id",     32'(want.item.id),    32'(rsp_bus.out_id));
            note_field("kept_count", 32'(want.count),      32'(rsp_bus.kept_count));
         end
      end
   end

   initial begin : watchdog
      #(RUN_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: files.f
sv/tkh_pkg.sv
sv/tkh_req_if.sv
sv/tkh_rsp_if.sv
sv/tkh_rank.sv
sv/tkh_seq.sv
sv/top_k_min_heap_selector.sv
sv/tkh_chk.sv
tb/sv/tb_top_k_min_heap_selector.sv
